@@ rtl/core/tlr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlr_pkg: shared definitions for the text command line recognizer
// Byte codes, command codes, the command text table and the compare result.
// ----------------------------------------------------------------------------
package tlr_pkg;

   localparam int LINE_CAPACITY_DEF = 32;
   localparam int POS_W             = 8;
   localparam int NUM_CMDS          = 4;
   localparam int CMD_TEXT_W        = 80;

   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_NUL = 8'h00;

   localparam logic [2:0] CODE_LED_ON     = 3'd0;
   localparam logic [2:0] CODE_LED_OFF    = 3'd1;
   localparam logic [2:0] CODE_LED_TOGGLE = 3'd2;
   localparam logic [2:0] CODE_STATUS     = 3'd3;
   localparam logic [2:0] CODE_UNKNOWN    = 3'd4;

   // Command texts are right-justified in the vector, first character highest.
   localparam logic [CMD_TEXT_W-1:0] CMD_TEXT [NUM_CMDS] = '{
      CMD_TEXT_W'("LED ON"), CMD_TEXT_W'("LED OFF"),
      CMD_TEXT_W'("LED TOGGLE"), CMD_TEXT_W'("STATUS")};
   localparam logic [POS_W-1:0] CMD_LEN [NUM_CMDS] = '{8'd6, 8'd7, 8'd10, 8'd6};

   typedef struct packed {
      logic [NUM_CMDS-1:0] match;
      logic                zero;
   } cmp_result_type;

   function automatic logic [7:0] cmd_char(input logic [1:0] k,
                                           input logic [POS_W-1:0] pos);
      logic [CMD_TEXT_W-1:0] text;
      logic [POS_W-1:0]      len;
      logic [7:0]            ch;
      text = CMD_TEXT[k];
      len  = CMD_LEN[k];
      ch   = BYTE_NUL;
      if (pos < len) begin
         ch = text[8*(int'(len) - 1 - int'(pos)) +: 8];
      end
      return ch;
   endfunction

   // Lowest command index wins; no candidate left means unknown.
   function automatic logic [2:0] classify(input logic [NUM_CMDS-1:0] flags,
                                           input logic [POS_W-1:0] eff);
      logic [2:0] code;
      code = CODE_UNKNOWN;
      for (int k = NUM_CMDS - 1; k >= 0; k--) begin
         if (flags[k] && (eff == CMD_LEN[k])) begin
            code = 3'(k);
         end
      end
      return code;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/text_command_line_recognizer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_command_line_recognizer: console line collector and command decoder
// Collects bytes into a line store and decodes a finished line into a code.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  req     | in        | req_valid/stall    | req_rx_byte
//  rsp     | out       | rsp_valid/stall    | line_done, command_code,
//          |           |                    | overflow_hit, overflow_total
//
// An ordinary byte is accepted, then its result goes into the result register.
// For a line terminator, n characters are compared in between (at most 11):
// each character is one registered read of the line store followed by one
// pass through the shared compare unit.
// Synchronous reset empties the line, leaves discard mode and clears the count.
// While a result word is stalled one more word is taken and processed; its
// result then waits, and no further word is taken until the stalled one drains.
// ----------------------------------------------------------------------------
module text_command_line_recognizer #(
   parameter int LINE_CAPACITY = tlr_pkg::LINE_CAPACITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_line_done,
   output logic [2:0]       rsp_command_code,
   output logic             rsp_overflow_hit,
   output logic [31:0]      rsp_overflow_total
);

   localparam int DEPTH  = LINE_CAPACITY - 1;
   localparam int LEN_W  = $clog2(LINE_CAPACITY);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;
   localparam logic [1:0] ST_PUT  = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic                         discard_ff, discard_in;
   logic [31:0]                  ovf_ff, ovf_in;
   logic [LEN_W-1:0]             idx_ff, idx_in;
   logic [tlr_pkg::NUM_CMDS-1:0] match_ff, match_in;
   logic                         res_done_ff, res_done_in;
   logic [2:0]                   res_code_ff, res_code_in;
   logic                         res_hit_ff, res_hit_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_done_ff;
   logic [2:0]                   rsp_code_ff;
   logic                         rsp_hit_ff;
   logic [31:0]                  rsp_total_ff;

   logic                         accept;
   logic                         is_term;
   logic                         store_wr;
   logic                         rsp_load;
   logic [7:0]                   rd_data;
   logic [LEN_W-1:0]             idx_nx;
   tlr_pkg::cmp_result_type      cmp_res;

   assign accept   = req_valid && !req_stall;
   assign is_term  = (req_rx_byte == tlr_pkg::BYTE_CR) || (req_rx_byte == tlr_pkg::BYTE_LF);
   assign store_wr = accept && !is_term && !discard_ff && (len_ff < DEPTH_L);
   assign rsp_load = (state_ff == ST_PUT) && (!rsp_valid_ff || !rsp_stall);
   assign idx_nx   = idx_ff + LEN_W'(1);

   tlr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (len_ff[ADDR_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   tlr_cmp u_cmp (
      .char_in  (rd_data),
      .pos      (tlr_pkg::POS_W'(idx_ff)),
      .match_in (match_ff),
      .result   (cmp_res)
   );

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      discard_in  = discard_ff;
      ovf_in      = ovf_ff;
      idx_in      = idx_ff;
      match_in    = match_ff;
      res_done_in = res_done_ff;
      res_code_in = res_code_ff;
      res_hit_in  = res_hit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_done_in = 1'b0;
               res_code_in = tlr_pkg::CODE_LED_ON;
               res_hit_in  = 1'b0;
               state_in    = ST_PUT;
               if (is_term) begin
                  if (discard_ff) begin
                     discard_in = 1'b0;
                     len_in     = '0;
                  end else if (len_ff != '0) begin
                     idx_in   = '0;
                     match_in = '1;
                     state_in = ST_READ;
                  end
               end else if (!discard_ff) begin
                  if (len_ff >= DEPTH_L) begin
                     ovf_in     = ovf_ff + 32'd1;
                     len_in     = '0;
                     discard_in = 1'b1;
                     res_hit_in = 1'b1;
                  end else begin
                     len_in = len_ff + LEN_W'(1);
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // A zero byte ends the text early; the line end or a dead candidate
            // set ends the scan as well.
            if (cmp_res.zero) begin
               res_code_in = tlr_pkg::classify(match_ff, tlr_pkg::POS_W'(idx_ff));
               res_done_in = 1'b1;
               len_in      = '0;
               state_in    = ST_PUT;
            end else if (idx_nx == len_ff) begin
               res_code_in = tlr_pkg::classify(cmp_res.match, tlr_pkg::POS_W'(len_ff));
               res_done_in = 1'b1;
               len_in      = '0;
               state_in    = ST_PUT;
            end else if (cmp_res.match == '0) begin
               res_code_in = tlr_pkg::CODE_UNKNOWN;
               res_done_in = 1'b1;
               len_in      = '0;
               state_in    = ST_PUT;
            end else begin
               match_in = cmp_res.match;
               idx_in   = idx_nx;
               state_in = ST_READ;
            end
         end
         ST_PUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         discard_ff   <= 1'b0;
         ovf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         discard_ff   <= discard_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      match_ff    <= match_in;
      res_done_ff <= res_done_in;
      res_code_ff <= res_code_in;
      res_hit_ff  <= res_hit_in;
      if (rsp_load) begin
         rsp_done_ff  <= res_done_ff;
         rsp_code_ff  <= res_code_ff;
         rsp_hit_ff   <= res_hit_ff;
         rsp_total_ff <= ovf_ff;
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_line_done      = rsp_done_ff;
   assign rsp_command_code   = rsp_code_ff;
   assign rsp_overflow_hit   = rsp_hit_ff;
   assign rsp_overflow_total = rsp_total_ff;

endmodule
`default_nettype wire

@@ rtl/core/tlr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tlr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 31
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/tlr_cmp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlr_cmp: shared character compare unit
// Checks one stored character against every command text at one position.
// ----------------------------------------------------------------------------
module tlr_cmp (
   input  wire logic [7:0]                   char_in,
   input  wire logic [tlr_pkg::POS_W-1:0]    pos,
   input  wire logic [tlr_pkg::NUM_CMDS-1:0] match_in,
   output tlr_pkg::cmp_result_type           result
);

   always_comb begin
      result.zero = (char_in == tlr_pkg::BYTE_NUL);
      for (int k = 0; k < tlr_pkg::NUM_CMDS; k++) begin
         result.match[k] = match_in[k] && (pos < tlr_pkg::CMD_LEN[k]) &&
                           (char_in == tlr_pkg::cmd_char(2'(k), pos));
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/tlr_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlr_checker: port-level checks for the text command line recognizer
// Watches both channels and the relation of the result fields.
// ----------------------------------------------------------------------------
module tlr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_rx_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_line_done,
   input wire logic [2:0]  rsp_command_code,
   input wire logic        rsp_overflow_hit,
   input wire logic [31:0] rsp_overflow_total
);

   // A stalled input word stays offered and keeps its byte.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_rx_byte))
      else $error("input word changed while stalled");

   // A stalled result word keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_done) &&
         $stable(rsp_command_code) && $stable(rsp_overflow_hit) &&
         $stable(rsp_overflow_total))
      else $error("result word changed while stalled");

   // One byte cannot both finish a line and overflow it.
   a_done_or_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_line_done && rsp_overflow_hit))
      else $error("line done and overflow in the same word");

   // Without a finished line the command code reads zero.
   a_code_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_done |-> rsp_command_code == tlr_pkg::CODE_LED_ON)
      else $error("command code set without a finished line");

   // The command code stays within its defined values.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_command_code <= tlr_pkg::CODE_UNKNOWN)
      else $error("command code out of range");

endmodule

bind text_command_line_recognizer tlr_checker u_tlr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_rx_byte        (req_rx_byte),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_line_done      (rsp_line_done),
   .rsp_command_code   (rsp_command_code),
   .rsp_overflow_hit   (rsp_overflow_hit),
   .rsp_overflow_total (rsp_overflow_total)
);
`default_nettype wire

@@ verif/line_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_result_checker: scoreboard for the text command line recognizer
// Watches both channels, works out the result of every accepted byte with its
// own line collector and command decoder, and compares it field by field with
// the result that the block hands out, oldest first.
// ----------------------------------------------------------------------------
module line_result_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_line_done,
   input  wire logic [2:0]  rsp_command_code,
   input  wire logic        rsp_overflow_hit,
   input  wire logic [31:0] rsp_overflow_total,
   output int               fail_count,
   output int               pending
);

   localparam int STORE_DEPTH = tlr_pkg::LINE_CAPACITY_DEF - 1;

   typedef struct packed {
      logic        done;
      logic [2:0]  code;
      logic        hit;
      logic [31:0] total;
   } line_result_type;

   string      cmd_words [tlr_pkg::NUM_CMDS] = '{"LED ON", "LED OFF", "LED TOGGLE",
                                                 "STATUS"};
   logic [2:0] cmd_codes [tlr_pkg::NUM_CMDS] = '{tlr_pkg::CODE_LED_ON,
                                                 tlr_pkg::CODE_LED_OFF,
                                                 tlr_pkg::CODE_LED_TOGGLE,
                                                 tlr_pkg::CODE_STATUS};

   logic [7:0]      line_buf [STORE_DEPTH];
   int              line_len;
   bit              discarding;
   logic [31:0]     ovf_count;
   line_result_type due_results [$];
   int              miss_count = 0;
   int              waiting = 0;

   assign fail_count = miss_count;
   assign pending    = waiting;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      miss_count++;
   endtask

   // The line only counts up to its first zero byte.
   function automatic logic [2:0] decode_line();
      int         eff;
      int         k;
      int         i;
      bit         same;
      logic [2:0] code;
      eff  = 0;
      code = tlr_pkg::CODE_UNKNOWN;
      while (eff < line_len && line_buf[eff] != tlr_pkg::BYTE_NUL) eff++;
      for (k = 0; k < tlr_pkg::NUM_CMDS; k++) begin
         if (code == tlr_pkg::CODE_UNKNOWN && eff == cmd_words[k].len()) begin
            same = 1'b1;
            for (i = 0; i < eff; i++) begin
               if (line_buf[i] != 8'(cmd_words[k][i])) same = 1'b0;
            end
            if (same) code = cmd_codes[k];
         end
      end
      return code;
   endfunction

   function automatic line_result_type digest_byte(input logic [7:0] b);
      line_result_type r;
      r = '0;
      if (b == tlr_pkg::BYTE_CR || b == tlr_pkg::BYTE_LF) begin
         if (discarding) begin
            discarding = 1'b0;
            line_len   = 0;
         end else if (line_len != 0) begin
            r.done   = 1'b1;
            r.code   = decode_line();
            line_len = 0;
         end
      end else if (!discarding) begin
         if (line_len >= STORE_DEPTH) begin
            ovf_count  = ovf_count + 32'd1;
            line_len   = 0;
            discarding = 1'b1;
            r.hit      = 1'b1;
         end else begin
            line_buf[line_len] = b;
            line_len++;
         end
      end
      r.total = ovf_count;
      return r;
   endfunction

   task automatic check_result();
      line_result_type want;
      if (due_results.size() == 0) begin
         report_mismatch("result with nothing expected", rsp_overflow_total, 32'd0);
      end else begin
         want = due_results.pop_front();
         if (rsp_line_done !== want.done)
            report_mismatch("line_done", 32'(rsp_line_done), 32'(want.done));
         if (rsp_command_code !== want.code)
            report_mismatch("command_code", 32'(rsp_command_code), 32'(want.code));
         if (rsp_overflow_hit !== want.hit)
            report_mismatch("overflow_hit", 32'(rsp_overflow_hit), 32'(want.hit));
         if (rsp_overflow_total !== want.total)
            report_mismatch("overflow_total", rsp_overflow_total, want.total);
      end
   endtask

   // The result is taken before the new byte: a byte never yields its result
   // at the edge where it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         line_len   = 0;
         discarding = 1'b0;
         ovf_count  = '0;
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) due_results.push_back(digest_byte(req_rx_byte));
      end
      waiting = due_results.size();
   end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the text command line recognizer
// Feeds console bytes as directed lines and then random lines (commands,
// damaged commands, zero bytes, overlong lines and noise) with random gaps
// and result stalls; the checker compares every result.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WORD_TARGET  = 1250;
   localparam int PHASE_WORDS  = 150;
   localparam int HOLD_AT      = 500;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_line_done;
   logic [2:0]  rsp_command_code;
   logic        rsp_overflow_hit;
   logic [31:0] rsp_overflow_total;
   int          fail_count;
   int          pending;
   int          words_sent = 0;
   int          drained = 0;
   int          quiet_cycles = 0;
   bit          idle_on = 1'b1;

   string cmd_words [tlr_pkg::NUM_CMDS] = '{"LED ON", "LED OFF", "LED TOGGLE", "STATUS"};

   text_command_line_recognizer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_done      (rsp_line_done),
      .rsp_command_code   (rsp_command_code),
      .rsp_overflow_hit   (rsp_overflow_hit),
      .rsp_overflow_total (rsp_overflow_total)
   );

   line_result_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_done      (rsp_line_done),
      .rsp_command_code   (rsp_command_code),
      .rsp_overflow_hit   (rsp_overflow_hit),
      .rsp_overflow_total (rsp_overflow_total),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int draw_gap();
      return idle_on ? int'($urandom_range(0, 11)) : 0;
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == tlr_pkg::BYTE_CR || b == tlr_pkg::BYTE_LF) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic logic [7:0] line_end();
      return $urandom_range(0, 1) ? tlr_pkg::BYTE_CR : tlr_pkg::BYTE_LF;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input logic [7:0] b);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_word(8'(s[i]));
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // Builds one random line (or a burst of noise) and sends it.
   task automatic send_random_line();
      logic [7:0] line_q [$];
      int         kind;
      int         k;
      int         n;
      int         pos;
      kind = $urandom_range(0, 99);
      k    = $urandom_range(0, tlr_pkg::NUM_CMDS - 1);
      line_q.delete();
      if (kind < 68) begin
         for (pos = 0; pos < cmd_words[k].len(); pos++) line_q.push_back(8'(cmd_words[k][pos]));
      end
      if (kind >= 45 && kind < 60) begin
         pos = $urandom_range(0, line_q.size() - 1);
         case ($urandom_range(0, 3))
            0: line_q[pos] = plain_byte();
            1: void'(line_q.pop_back());
            2: line_q.push_back(plain_byte());
            default: line_q[pos] = line_q[pos] ^ 8'h20;
         endcase
      end else if (kind >= 60 && kind < 68) begin
         // Anything after a zero byte is ignored by the compare.
         line_q.push_back(tlr_pkg::BYTE_NUL);
         n = $urandom_range(0, 30 - line_q.size());
         repeat (n) line_q.push_back(plain_byte());
      end else if (kind >= 68 && kind < 80) begin
         n = $urandom_range(0, 31);
         repeat (n) line_q.push_back(plain_byte());
      end else if (kind >= 80 && kind < 90) begin
         n = $urandom_range(31, 45);
         repeat (n) line_q.push_back(plain_byte());
      end else if (kind >= 90) begin
         n = $urandom_range(1, 8);
         repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
      end
      if (kind < 90) line_q.push_back(line_end());
      foreach (line_q[i]) send_word(line_q[i]);
   endtask

   initial begin : result_sink
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = draw_gap();
         // One long hold-off so that the block fills and stalls its input.
         if (drained == HOLD_AT) n = HOLD_CYCLES;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         drained++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int next_phase;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_text("LED OFF\r");
      send_word(tlr_pkg::BYTE_LF);
      send_text("LED TOGGLE\n");
      // A line that starts with a zero byte is unknown.
      send_word(tlr_pkg::BYTE_NUL);
      send_word(8'hFF);
      send_word(tlr_pkg::BYTE_CR);
      drain_all();

      next_phase = words_sent + PHASE_WORDS;
      while (words_sent < WORD_TARGET) begin
         send_random_line();
         if (words_sent >= next_phase) begin
            next_phase = words_sent + PHASE_WORDS;
            idle_on    = !idle_on;
            if ($urandom_range(0, 1)) drain_all();
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/tlr_pkg.sv
rtl/core/tlr_ram.sv
rtl/core/tlr_cmp.sv
rtl/core/text_command_line_recognizer.sv
rtl/core/tlr_checker.sv
verif/line_result_checker.sv
verif/tb_top.sv
